// ===== sv/fgtc_pkg.sv =====
// Package with the shared types, constants and arithmetic helpers of the green-time controller.
`timescale 1ns / 1ps

package fgtc_pkg;

	// Membership and rule widths.
	localparam int MEMB_W  = 7;
	localparam int STR_W   = 9;
	localparam int TOT_W   = 10;
	localparam int DUR_W   = 8;
	localparam int PROD_W  = STR_W + DUR_W;
	localparam int REM_W   = PROD_W + 1;
	localparam int QUO_W   = 8;
	localparam int IN_W    = 6;
	localparam int NCLASS  = 3;

	// Divider steps, one quotient bit per stage.
	localparam int DIV_STEPS = QUO_W;

	// Cycles from an accepted word to its done strobe.
	localparam int PIPE_LATENCY = 4 + DIV_STEPS;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 2;

	// Ramp constants.
	localparam logic [MEMB_W-1:0] SLOPE_PCT = 7'd10;
	localparam logic [MEMB_W-1:0] FULL_PCT  = 7'd100;

	localparam logic [IN_W-1:0] CNT_B0 = 6'd7;
	localparam logic [IN_W-1:0] CNT_B1 = 6'd13;
	localparam logic [IN_W-1:0] CNT_B2 = 6'd17;
	localparam logic [IN_W-1:0] CNT_B3 = 6'd23;
	localparam logic [IN_W-1:0] SPD_B0 = 6'd15;
	localparam logic [IN_W-1:0] SPD_B1 = 6'd25;
	localparam logic [IN_W-1:0] SPD_B2 = 6'd35;
	localparam logic [IN_W-1:0] SPD_B3 = 6'd45;

	// Configuration register indexes and reset values.
	localparam logic [1:0] REG_SHORT  = 2'd0;
	localparam logic [1:0] REG_MEDIUM = 2'd1;
	localparam logic [1:0] REG_LONG   = 2'd2;
	localparam logic [1:0] REG_NONE   = 2'd3;

	localparam logic [DUR_W-1:0] SHORT_RST  = 8'd30;
	localparam logic [DUR_W-1:0] MEDIUM_RST = 8'd60;
	localparam logic [DUR_W-1:0] LONG_RST   = 8'd90;

	typedef logic [NCLASS-1:0][MEMB_W-1:0] memb_t;
	typedef logic [NCLASS-1:0][STR_W-1:0]  str_t;
	typedef logic [NCLASS-1:0][DUR_W-1:0]  dur_t;
	typedef logic [NCLASS-1:0][PROD_W-1:0] prod_t;

	// One classified word: per count class strength and the total strength.
	typedef struct packed {
		str_t             strength;
		logic [TOT_W-1:0] total;
	} word_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

	// State carried through the divider stages.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [TOT_W-1:0] total;
		logic [QUO_W-1:0] quo;
	} div_t;

	// Three-class piecewise-linear fuzzifier with a fixed slope.
	function automatic memb_t fuzzify(input logic [IN_W-1:0] x, input logic [IN_W-1:0] b0,
			input logic [IN_W-1:0] b1, input logic [IN_W-1:0] b2, input logic [IN_W-1:0] b3);
		memb_t             m;
		logic [IN_W-1:0]   d_lo;
		logic [IN_W-1:0]   d_hi;
		logic [MEMB_W-1:0] r_lo;
		logic [MEMB_W-1:0] r_hi;
		d_lo = x - b0;
		d_hi = x - b2;
		r_lo = MEMB_W'(d_lo[3:0]) * SLOPE_PCT;
		r_hi = MEMB_W'(d_hi[3:0]) * SLOPE_PCT;
		if (x <= b0) begin
			m[0] = FULL_PCT;
			m[1] = '0;
			m[2] = '0;
		end else if (x <= b1) begin
			m[1] = r_lo;
			m[0] = FULL_PCT - r_lo;
			m[2] = '0;
		end else if (x <= b2) begin
			m[0] = '0;
			m[1] = FULL_PCT;
			m[2] = '0;
		end else if (x <= b3) begin
			m[2] = r_hi;
			m[1] = FULL_PCT - r_hi;
			m[0] = '0;
		end else begin
			m[0] = '0;
			m[1] = '0;
			m[2] = FULL_PCT;
		end
		return m;
	endfunction

	function automatic logic [MEMB_W-1:0] min_memb(input logic [MEMB_W-1:0] a,
			input logic [MEMB_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// One restoring division step that decides quotient bit k.
	// A zero divisor leaves every quotient bit clear, so the result is zero.
	function automatic div_t div_step(input div_t d, input logic [2:0] k);
		div_t             n;
		logic [REM_W-1:0] cand;
		n = d;
		cand = REM_W'(d.total) << k;
		if ((d.total != '0) && (d.rem >= cand)) begin
			n.rem = d.rem - cand;
			n.quo[k] = 1'b1;
		end
		return n;
	endfunction

endpackage

// ===== sv/fuzzy_green_time_controller.sv =====
// Top level of the fuzzy green-time controller: configuration registers and the front, queue and back.
`timescale 1ns / 1ps

// A word (vehicle_count, average_speed) is taken at a clock edge where start is high and busy is
// low, and its green_seconds leaves the divider with a one-cycle done strobe; results cannot
// be held off and must be captured in that cycle. A new word may be started every cycle, so the
// block sustains one word per clock. Each word passes through one fuzzify stage, the queue, one
// multiply stage, one sum stage and an eight-stage restoring divider that settles one quotient
// bit per stage. busy rises only when the front stage holds a word and the two-word queue is
// full, which does not happen in practice because the back pipeline drains the queue every cycle.
// The three durations are written through cfg_we, cfg_index and cfg_wdata and should be changed
// only while no word is in flight; index 3 is ignored.
module fuzzy_green_time_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fgtc_pkg::IN_W-1:0]     vehicle_count,
	input  logic [fgtc_pkg::IN_W-1:0]     average_speed,
	output logic                          done,
	output logic [fgtc_pkg::QUO_W-1:0]    green_seconds,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [fgtc_pkg::DUR_W-1:0]    cfg_wdata
);

	fgtc_pkg::dur_t    dur_q;
	fgtc_pkg::qstat_t  qstat;
	fgtc_pkg::word_t   push_word;
	fgtc_pkg::word_t   pop_word;
	logic              push_valid;

	// Duration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q[0] <= fgtc_pkg::SHORT_RST;
			dur_q[1] <= fgtc_pkg::MEDIUM_RST;
			dur_q[2] <= fgtc_pkg::LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fgtc_pkg::REG_SHORT: begin
					dur_q[0] <= cfg_wdata;
				end
				fgtc_pkg::REG_MEDIUM: begin
					dur_q[1] <= cfg_wdata;
				end
				fgtc_pkg::REG_LONG: begin
					dur_q[2] <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	fgtc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.vehicle_count (vehicle_count),
		.average_speed (average_speed),
		.qstat         (qstat),
		.push_valid    (push_valid),
		.push_word     (push_word)
	);

	fgtc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.qstat      (qstat),
		.pop_word   (pop_word)
	);

	fgtc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (qstat.nonempty),
		.in_word       (pop_word),
		.dur           (dur_q),
		.done          (done),
		.green_seconds (green_seconds)
	);

`ifndef SYNTHESIS
	// Every accepted word comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(fgtc_pkg::PIPE_LATENCY) done)
		else $error("accepted word did not complete on time");

	// The back pipeline drains the queue every cycle, so the front never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("front stalled on a full queue");

	// A write to the unused index leaves every duration unchanged.
	a_unused_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == fgtc_pkg::REG_NONE)) |=> $stable(dur_q))
		else $error("write to unused index changed a duration");
`endif

endmodule

// ===== sv/fgtc_front.sv =====
// Front stage: accepts a word, fuzzifies both inputs and forms the per-class rule strengths.
`timescale 1ns / 1ps

module fgtc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fgtc_pkg::IN_W-1:0]     vehicle_count,
	input  logic [fgtc_pkg::IN_W-1:0]     average_speed,
	input  fgtc_pkg::qstat_t              qstat,
	output logic                          push_valid,
	output fgtc_pkg::word_t               push_word
);

	logic                  vld_s1;
	fgtc_pkg::word_t       word_s1;
	fgtc_pkg::memb_t       mc;
	fgtc_pkg::memb_t       ms;
	fgtc_pkg::word_t       word_d;
	logic                  adv;

	// The stage moves on when it is empty or its word goes into the queue.
	assign adv  = !vld_s1 || !qstat.full;
	assign busy = !adv;

	// Fuzzify and combine: each count class sums its three rule minimums.
	always_comb begin
		mc = fgtc_pkg::fuzzify(vehicle_count, fgtc_pkg::CNT_B0, fgtc_pkg::CNT_B1,
			fgtc_pkg::CNT_B2, fgtc_pkg::CNT_B3);
		ms = fgtc_pkg::fuzzify(average_speed, fgtc_pkg::SPD_B0, fgtc_pkg::SPD_B1,
			fgtc_pkg::SPD_B2, fgtc_pkg::SPD_B3);
		word_d.total = '0;
		for (int i = 0; i < fgtc_pkg::NCLASS; i++) begin
			word_d.strength[i] =
				fgtc_pkg::STR_W'(fgtc_pkg::min_memb(mc[i], ms[0])) +
				fgtc_pkg::STR_W'(fgtc_pkg::min_memb(mc[i], ms[1])) +
				fgtc_pkg::STR_W'(fgtc_pkg::min_memb(mc[i], ms[2]));
			word_d.total = word_d.total + fgtc_pkg::TOT_W'(word_d.strength[i]);
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv && start) begin
			word_s1 <= word_d;
		end
	end

	assign push_valid = vld_s1;
	assign push_word  = word_s1;

endmodule

// ===== sv/fgtc_queue.sv =====
// Short queue that decouples the front stage from the back pipeline.
`timescale 1ns / 1ps

module fgtc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  fgtc_pkg::word_t   push_word,
	output fgtc_pkg::qstat_t  qstat,
	output fgtc_pkg::word_t   pop_word
);

	localparam int PTR_W = $clog2(fgtc_pkg::QDEPTH);
	localparam int CNT_W = $clog2(fgtc_pkg::QDEPTH + 1);

	fgtc_pkg::word_t   mem_q [fgtc_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign qstat.full     = (count_q == CNT_W'(fgtc_pkg::QDEPTH));
	assign qstat.nonempty = (count_q != '0);

	// The back pipeline never stalls, so the head word leaves whenever there is one.
	assign push = push_valid && !qstat.full;
	assign pop  = qstat.nonempty;

	assign pop_word = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fgtc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fgtc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/fgtc_back.sv =====
// Back pipeline: weights the class strengths by the durations and divides by the total strength.
`timescale 1ns / 1ps

module fgtc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  fgtc_pkg::word_t               in_word,
	input  fgtc_pkg::dur_t                dur,
	output logic                          done,
	output logic [fgtc_pkg::QUO_W-1:0]    green_seconds
);

	logic                           vld_s1;
	fgtc_pkg::prod_t                prod_s1;
	logic [fgtc_pkg::TOT_W-1:0]     tot_s1;
	logic [fgtc_pkg::DIV_STEPS:0]   div_vld_s;
	fgtc_pkg::div_t                 div_s [fgtc_pkg::DIV_STEPS+1];

	// Valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			div_vld_s <= '0;
		end else begin
			vld_s1    <= in_valid;
			div_vld_s <= {div_vld_s[fgtc_pkg::DIV_STEPS-1:0], vld_s1};
		end
	end

	// Multiply each class strength by its duration.
	always_ff @(posedge clk) begin
		for (int i = 0; i < fgtc_pkg::NCLASS; i++) begin
			prod_s1[i] <= fgtc_pkg::PROD_W'(in_word.strength[i]) *
				fgtc_pkg::PROD_W'(dur[i]);
		end
		tot_s1 <= in_word.total;
	end

	// Sum the weighted strengths to load the divider.
	always_ff @(posedge clk) begin
		div_s[0].rem   <= fgtc_pkg::REM_W'(prod_s1[0]) + fgtc_pkg::REM_W'(prod_s1[1]) +
			fgtc_pkg::REM_W'(prod_s1[2]);
		div_s[0].total <= tot_s1;
		div_s[0].quo   <= '0;
	end

	// Restoring division, most significant quotient bit first.
	for (genvar k = 1; k <= fgtc_pkg::DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			div_s[k] <= fgtc_pkg::div_step(div_s[k-1], 3'(fgtc_pkg::DIV_STEPS - k));
		end
	end

	assign done          = div_vld_s[fgtc_pkg::DIV_STEPS];
	assign green_seconds = div_s[fgtc_pkg::DIV_STEPS].quo;

endmodule

// ===== test/fuzzy_green_time_controller_tb.sv =====
// Self-checking testbench for the fuzzy green-time controller with its own green-time predictor.
`timescale 1ns / 1ps

module fuzzy_green_time_controller_tb;

	// One traffic word as driven into the block.
	typedef struct {
		logic [fgtc_pkg::IN_W-1:0] count;
		logic [fgtc_pkg::IN_W-1:0] speed;
	} traffic_word_t;

	// Predicted green time, kept with the word that caused it.
	typedef struct {
		logic [fgtc_pkg::IN_W-1:0]  count;
		logic [fgtc_pkg::IN_W-1:0]  speed;
		logic [fgtc_pkg::QUO_W-1:0] green;
	} green_expect_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [fgtc_pkg::IN_W-1:0]     vehicle_count = '0;
	logic [fgtc_pkg::IN_W-1:0]     average_speed = '0;
	logic                          done;
	logic [fgtc_pkg::QUO_W-1:0]    green_seconds;
	logic                          cfg_we = 1'b0;
	logic [1:0]                    cfg_index = fgtc_pkg::REG_SHORT;
	logic [fgtc_pkg::DUR_W-1:0]    cfg_wdata = '0;

	traffic_word_t                 pending_words[$];
	green_expect_t                 green_due[$];
	logic [fgtc_pkg::DUR_W-1:0]    duration_set [fgtc_pkg::NCLASS];
	bit                            steady_feed = 1'b0;
	int                            error_count = 0;

	fuzzy_green_time_controller uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.vehicle_count (vehicle_count),
		.average_speed (average_speed),
		.done          (done),
		.green_seconds (green_seconds),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Grade one input into its low, middle and high class in percent.
	function automatic fgtc_pkg::memb_t grade(input int x, input int b0, input int b1,
			input int b2, input int b3);
		fgtc_pkg::memb_t m;
		int              rise;
		m = '0;
		if (x <= b0) begin
			m[0] = 7'(100);
		end else if (x <= b1) begin
			rise = (x - b0) * 10;
			m[1] = 7'(rise);
			m[0] = 7'(100 - rise);
		end else if (x <= b2) begin
			m[1] = 7'(100);
		end else if (x <= b3) begin
			rise = (x - b2) * 10;
			m[2] = 7'(rise);
			m[1] = 7'(100 - rise);
		end else begin
			m[2] = 7'(100);
		end
		return m;
	endfunction

	// Weighted average of the durations over the nine rule strengths, truncated.
	function automatic logic [fgtc_pkg::QUO_W-1:0] predict_green(
			input logic [fgtc_pkg::IN_W-1:0] count, input logic [fgtc_pkg::IN_W-1:0] speed);
		fgtc_pkg::memb_t mc;
		fgtc_pkg::memb_t ms;
		int              strength;
		int              total;
		int              weighted;
		mc = grade(count, fgtc_pkg::CNT_B0, fgtc_pkg::CNT_B1, fgtc_pkg::CNT_B2,
			fgtc_pkg::CNT_B3);
		ms = grade(speed, fgtc_pkg::SPD_B0, fgtc_pkg::SPD_B1, fgtc_pkg::SPD_B2,
			fgtc_pkg::SPD_B3);
		total = 0;
		weighted = 0;
		for (int i = 0; i < fgtc_pkg::NCLASS; i++) begin
			for (int j = 0; j < fgtc_pkg::NCLASS; j++) begin
				strength = (mc[i] < ms[j]) ? mc[i] : ms[j];
				total += strength;
				weighted += strength * duration_set[i];
			end
		end
		return (total != 0) ? fgtc_pkg::QUO_W'(weighted / total) : '0;
	endfunction

	// Driver: records each accepted word and presents the next pending one, with random gaps unless steady_feed is set.
	always @(posedge clk or negedge arst_n) begin
		traffic_word_t w;
		if (!arst_n) begin
			start <= 1'b0;
			vehicle_count <= '0;
			average_speed <= '0;
		end else begin
			if (start && !busy) begin
				green_due.push_back('{vehicle_count, average_speed,
					predict_green(vehicle_count, average_speed)});
			end
			if (!start || !busy) begin
				if (pending_words.size() != 0 && (steady_feed || $urandom_range(99, 0) >= 24)) begin
					w = pending_words.pop_front();
					start <= 1'b1;
					vehicle_count <= w.count;
					average_speed <= w.speed;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done strobe must match the oldest predicted green time.
	always @(posedge clk) begin
		green_expect_t e;
		if (arst_n && done) begin
			if (green_due.size() == 0) begin
				$display("%0t: unexpected green_seconds %0d with no word outstanding",
					$realtime, green_seconds);
				error_count++;
			end else begin
				e = green_due.pop_front();
				if (green_seconds !== e.green) begin
					$display("%0t: green_seconds for count %0d speed %0d: expected %0d, actual %0d",
						$realtime, e.count, e.speed, e.green, green_seconds);
					error_count++;
				end
			end
		end
	end

	// Write one duration register; an index past the list must leave all of them alone.
	task automatic write_duration(input logic [1:0] idx, input logic [fgtc_pkg::DUR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < fgtc_pkg::NCLASS)
			duration_set[idx] = val;
	endtask

	// Wait until every queued word has gone in and every result has come back.
	// Checking on the falling edge sees the driver's updates of the last rising edge.
	task automatic wait_drained();
		while (pending_words.size() != 0 || start || green_due.size() != 0)
			@(negedge clk);
	endtask

	// Mostly nominal traffic, with some words over the whole field range.
	function automatic traffic_word_t random_word();
		traffic_word_t w;
		w.count = ($urandom_range(9, 0) < 7) ? fgtc_pkg::IN_W'($urandom_range(30, 0))
			: fgtc_pkg::IN_W'($urandom_range(63, 0));
		w.speed = ($urandom_range(9, 0) < 7) ? fgtc_pkg::IN_W'($urandom_range(60, 0))
			: fgtc_pkg::IN_W'($urandom_range(63, 0));
		return w;
	endfunction

	// Set all three durations and write a random value to the unused index, then run a batch of random words.
	task automatic run_setting(input logic [fgtc_pkg::DUR_W-1:0] s,
			input logic [fgtc_pkg::DUR_W-1:0] m, input logic [fgtc_pkg::DUR_W-1:0] l,
			input int n_words, input bit steady);
		write_duration(fgtc_pkg::REG_SHORT, s);
		write_duration(fgtc_pkg::REG_MEDIUM, m);
		write_duration(fgtc_pkg::REG_LONG, l);
		write_duration(fgtc_pkg::REG_NONE, fgtc_pkg::DUR_W'($urandom_range(255, 0)));
		steady_feed = steady;
		repeat (n_words)
			pending_words.push_back(random_word());
		wait_drained();
		steady_feed = 1'b0;
	endtask

	// Run stimulus: directed words at the reset durations, then random words per setting.
	initial begin
		traffic_word_t edge_words [$];
		duration_set[fgtc_pkg::REG_SHORT] = fgtc_pkg::SHORT_RST;
		duration_set[fgtc_pkg::REG_MEDIUM] = fgtc_pkg::MEDIUM_RST;
		duration_set[fgtc_pkg::REG_LONG] = fgtc_pkg::LONG_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes, every ramp breakpoint and the counts and speeds above range.
		edge_words = '{'{6'd0, 6'd0}, '{6'd63, 6'd63}, '{6'd0, 6'd63}, '{6'd63, 6'd0},
			'{6'd7, 6'd15}, '{6'd8, 6'd16}, '{6'd10, 6'd20}, '{6'd13, 6'd25},
			'{6'd14, 6'd26}, '{6'd17, 6'd35}, '{6'd18, 6'd36}, '{6'd20, 6'd40},
			'{6'd23, 6'd45}, '{6'd24, 6'd46}, '{6'd30, 6'd60}, '{6'd12, 6'd30},
			'{6'd5, 6'd50}, '{6'd21, 6'd22}, '{6'd16, 6'd44}, '{6'd9, 6'd33}};
		foreach (edge_words[i])
			pending_words.push_back(edge_words[i]);
		wait_drained();

		run_setting(8'd0, 8'd0, 8'd0, 20, 1'b0);
		run_setting(8'd255, 8'd255, 8'd255, 30, 1'b0);
		run_setting(8'd255, 8'd0, 8'd128, 50, 1'b0);
		run_setting(8'd0, 8'd128, 8'd255, 60, 1'b1);
		run_setting(8'd1, 8'd254, 8'd7, 50, 1'b0);
		repeat (3)
			run_setting(fgtc_pkg::DUR_W'($urandom_range(255, 0)),
				fgtc_pkg::DUR_W'($urandom_range(255, 0)),
				fgtc_pkg::DUR_W'($urandom_range(255, 0)), 60, 1'b0);

		// Let any stray result surface before the verdict.
		repeat (fgtc_pkg::PIPE_LATENCY + 4) @(posedge clk);
		if (green_due.size() != 0) begin
			$display("%0t: %0d green times never arrived", $realtime, green_due.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog in case the block stops answering.
	initial begin
		#2_000_000;
		$display("%0t: timeout", $realtime);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
